/* rtl/core/tcu_pkg.sv */
// Shared types, codes and widths for the terminal cursor and tab unit.
package tcu_pkg;

  localparam int OP_W    = 3;
  localparam int CNT_W   = 16;
  localparam int POS_W   = 8;
  localparam int SCAN_W  = 9;
  localparam int CFG_W   = 9;
  localparam int CFG_IDX_W = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_FWD_TAB   = 3'd0;
  localparam logic [OP_W-1:0] OP_BACK_TAB  = 3'd1;
  localparam logic [OP_W-1:0] OP_CLR_STOP  = 3'd2;
  localparam logic [OP_W-1:0] OP_CLR_ALL   = 3'd3;
  localparam logic [OP_W-1:0] OP_NEXT_LINE = 3'd4;
  localparam logic [OP_W-1:0] OP_PREV_LINE = 3'd5;
  localparam logic [OP_W-1:0] OP_SET_STOP  = 3'd6;
  localparam logic [OP_W-1:0] OP_SET_CUR   = 3'd7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;

  localparam logic [CFG_W-1:0] COLUMNS_RST = 9'd80;
  localparam logic [CFG_W-1:0] ROWS_RST    = 9'd24;

  typedef struct packed {
    logic load;       // latch an accepted request, prime the first map read
    logic apply;      // single-cycle cursor / stop update
    logic scan_f;     // forward stop walk
    logic scan_b;     // backward stop walk
    logic sweep;      // write one map entry per cycle
    logic sweep_pat;  // sweep writes the power-on stop pattern, else zero
    logic out_load;   // copy cursor into the output register
  } cmd_t;

  typedef struct packed {
    logic col_zero;
    logic scan_fin;
    logic sweep_last;
  } stat_t;

endpackage

/* rtl/core/tcu_in_if.sv */
// Request channel: operation and its arguments.
interface tcu_in_if;
  logic                          valid;
  logic                          ready;
  logic [tcu_pkg::OP_W-1:0]      operation;
  logic [tcu_pkg::CNT_W-1:0]     count;
  logic [tcu_pkg::POS_W-1:0]     target_row;
  logic [tcu_pkg::POS_W-1:0]     target_col;

  modport source (output valid, operation, count, target_row, target_col, input ready);
  modport sink   (input valid, operation, count, target_row, target_col, output ready);
endinterface

/* rtl/core/tcu_out_if.sv */
// Result channel: cursor position after each request.
interface tcu_out_if;
  logic                      valid;
  logic                      ready;
  logic [tcu_pkg::POS_W-1:0] row_now;
  logic [tcu_pkg::POS_W-1:0] col_now;

  modport source (output valid, row_now, col_now, input ready);
  modport sink   (input valid, row_now, col_now, output ready);
endinterface

/* rtl/core/tcu_cfg_if.sv */
// Configuration write channel: register index and data.
interface tcu_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tcu_pkg::CFG_IDX_W-1:0] index;
  logic [tcu_pkg::CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/tcu_ctrl.sv */
// Sequencer for the cursor and tab unit: request intake, walks, sweeps, result hand-off.
module tcu_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [tcu_pkg::OP_W-1:0] in_op,
  output logic                     in_ready,
  input  logic                     out_ready,
  output logic                     out_valid,
  input  tcu_pkg::stat_t           stat,
  output tcu_pkg::cmd_t            cmd
);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_APPLY = 3'd2;
  localparam logic [2:0] S_SCANF = 3'd3;
  localparam logic [2:0] S_SCANB = 3'd4;
  localparam logic [2:0] S_WIPE  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_INIT: begin
        cmd.sweep     = 1'b1;
        cmd.sweep_pat = 1'b1;
        if (stat.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (in_op)
            tcu_pkg::OP_FWD_TAB:  state_nxt = S_SCANF;
            tcu_pkg::OP_BACK_TAB: state_nxt = stat.col_zero ? S_DONE : S_SCANB;
            tcu_pkg::OP_CLR_ALL:  state_nxt = S_WIPE;
            default:              state_nxt = S_APPLY;
          endcase
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_DONE;
      end
      S_SCANF: begin
        cmd.scan_f = 1'b1;
        if (stat.scan_fin) state_nxt = S_DONE;
      end
      S_SCANB: begin
        cmd.scan_b = 1'b1;
        if (stat.scan_fin) state_nxt = S_DONE;
      end
      S_WIPE: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_comb begin
    if (cmd.out_load)   out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/core/tcu_datapath.sv */
// Cursor registers, tab-stop map memory, stop walker and result register.
module tcu_datapath #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tcu_pkg::cmd_t                 cmd,
  output tcu_pkg::stat_t                stat,
  input  logic [tcu_pkg::OP_W-1:0]      in_op,
  input  logic [tcu_pkg::CNT_W-1:0]     in_count,
  input  logic [tcu_pkg::POS_W-1:0]     in_trow,
  input  logic [tcu_pkg::POS_W-1:0]     in_tcol,
  input  logic                          cfg_we,
  input  logic [tcu_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [tcu_pkg::CFG_W-1:0]     cfg_data,
  output logic [tcu_pkg::POS_W-1:0]     out_row,
  output logic [tcu_pkg::POS_W-1:0]     out_col
);

  localparam int MAP_DEPTH = (MAX_COLUMNS < 256) ? MAX_COLUMNS : 256;
  localparam int ROW_TOP   = (MAX_ROWS < 256) ? MAX_ROWS : 256;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam logic [tcu_pkg::SCAN_W-1:0] MAP_LIM = tcu_pkg::SCAN_W'(MAP_DEPTH);
  localparam logic [tcu_pkg::CFG_W-1:0]  ROW_LIM = tcu_pkg::CFG_W'(ROW_TOP);
  localparam logic [MAP_AW-1:0]          SW_LAST = MAP_AW'(MAP_DEPTH - 1);
  localparam int SUM_W = tcu_pkg::CNT_W + 1;

  logic [tcu_pkg::CFG_W-1:0]  cfg_cols_r, cfg_rows_r;
  logic [tcu_pkg::POS_W-1:0]  col_r, col_nxt, row_r, row_nxt;
  logic [tcu_pkg::OP_W-1:0]   op_r;
  logic [tcu_pkg::CNT_W-1:0]  rem_r, rem_nxt;
  logic [tcu_pkg::POS_W-1:0]  trow_r, tcol_r;
  logic [tcu_pkg::SCAN_W-1:0] chk_r, chk_nxt;
  logic [MAP_AW-1:0]          sw_r;
  logic [tcu_pkg::POS_W-1:0]  out_row_r, out_col_r;

  logic                       map_mem [MAP_DEPTH];
  logic                       rd_q_r;
  logic                       rd_en, wr_en, wr_data;
  logic [tcu_pkg::SCAN_W-1:0] rd_addr9;
  logic [MAP_AW-1:0]          wr_addr;

  logic [tcu_pkg::CFG_W-1:0]  cols_eff, rows_eff, cols_m1, rows_m1;
  logic [tcu_pkg::SCAN_W-1:0] col_p1, col_m1, chk_p1, chk_m1;
  logic [SUM_W-1:0]           row_sum;
  logic [tcu_pkg::CNT_W-1:0]  n_eff;
  logic                       at_end, hit, fin;

  always_comb begin
    if (cfg_cols_r == '0)        cols_eff = tcu_pkg::CFG_W'(1);
    else if (cfg_cols_r > MAP_LIM) cols_eff = MAP_LIM;
    else                         cols_eff = cfg_cols_r;
    if (cfg_rows_r == '0)        rows_eff = tcu_pkg::CFG_W'(1);
    else if (cfg_rows_r > ROW_LIM) rows_eff = ROW_LIM;
    else                         rows_eff = cfg_rows_r;
  end

  assign cols_m1 = cols_eff - tcu_pkg::CFG_W'(1);
  assign rows_m1 = rows_eff - tcu_pkg::CFG_W'(1);
  assign col_p1  = {1'b0, col_r} + tcu_pkg::SCAN_W'(1);
  assign col_m1  = {1'b0, col_r} - tcu_pkg::SCAN_W'(1);
  assign chk_p1  = chk_r + tcu_pkg::SCAN_W'(1);
  assign chk_m1  = chk_r - tcu_pkg::SCAN_W'(1);
  assign row_sum = SUM_W'(row_r) + SUM_W'(rem_r);
  assign n_eff   = (in_count == '0) ? tcu_pkg::CNT_W'(1) : in_count;

  // one column is checked per cycle; rd_q_r holds the map bit of chk_r
  always_comb begin
    at_end = 1'b0;
    hit    = 1'b0;
    fin    = 1'b0;
    if (cmd.scan_b) begin
      hit = (chk_r < MAP_LIM) && rd_q_r;
      fin = (hit && rem_r == tcu_pkg::CNT_W'(1)) || (chk_r == '0);
    end else begin
      at_end = chk_r >= cols_eff;
      hit    = !at_end && rd_q_r;
      fin    = at_end || (hit && rem_r == tcu_pkg::CNT_W'(1));
    end
  end

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    rem_nxt  = rem_r;
    chk_nxt  = chk_r;
    rd_en    = 1'b0;
    rd_addr9 = chk_p1;
    wr_en    = 1'b0;
    wr_addr  = sw_r;
    wr_data  = 1'b0;

    if (cmd.load) begin
      rem_nxt = n_eff;
      if (in_op == tcu_pkg::OP_BACK_TAB) begin
        chk_nxt  = col_m1;
        rd_addr9 = col_m1;
        rd_en    = (col_r != '0) && (col_m1 < MAP_LIM);
      end else begin
        chk_nxt  = col_p1;
        rd_addr9 = col_p1;
        rd_en    = col_p1 < MAP_LIM;
      end
    end

    if (cmd.scan_f) begin
      if (at_end) col_nxt = cols_m1[tcu_pkg::POS_W-1:0];
      else if (hit) begin
        col_nxt = chk_r[tcu_pkg::POS_W-1:0];
        rem_nxt = rem_r - tcu_pkg::CNT_W'(1);
      end
      chk_nxt  = chk_p1;
      rd_addr9 = chk_p1;
      rd_en    = chk_p1 < MAP_LIM;
    end

    if (cmd.scan_b) begin
      if (hit) begin
        col_nxt = chk_r[tcu_pkg::POS_W-1:0];
        rem_nxt = rem_r - tcu_pkg::CNT_W'(1);
      end else if (chk_r == '0) begin
        col_nxt = '0;
      end
      chk_nxt  = chk_m1;
      rd_addr9 = chk_m1;
      rd_en    = (chk_r != '0) && (chk_m1 < MAP_LIM);
    end

    if (cmd.sweep) begin
      wr_en   = 1'b1;
      wr_addr = sw_r;
      wr_data = cmd.sweep_pat && (sw_r[2:0] == 3'd0);
    end

    if (cmd.apply) begin
      case (op_r)
        tcu_pkg::OP_CLR_STOP, tcu_pkg::OP_SET_STOP: begin
          // stops off the visible screen are left alone
          wr_en   = {1'b0, col_r} < cols_eff;
          wr_addr = col_r[MAP_AW-1:0];
          wr_data = (op_r == tcu_pkg::OP_SET_STOP);
        end
        tcu_pkg::OP_NEXT_LINE: begin
          row_nxt = (row_sum < SUM_W'(rows_m1)) ? row_sum[tcu_pkg::POS_W-1:0]
                                                 : rows_m1[tcu_pkg::POS_W-1:0];
          col_nxt = '0;
        end
        tcu_pkg::OP_PREV_LINE: begin
          row_nxt = (tcu_pkg::CNT_W'(row_r) > rem_r)
                    ? row_r - rem_r[tcu_pkg::POS_W-1:0] : '0;
          col_nxt = '0;
        end
        tcu_pkg::OP_SET_CUR: begin
          row_nxt = ({1'b0, trow_r} < rows_m1) ? trow_r : rows_m1[tcu_pkg::POS_W-1:0];
          col_nxt = ({1'b0, tcol_r} < cols_m1) ? tcol_r : cols_m1[tcu_pkg::POS_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) map_mem[wr_addr] <= wr_data;
    if (rd_en) rd_q_r <= map_mem[rd_addr9[MAP_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_cols_r <= tcu_pkg::COLUMNS_RST;
      cfg_rows_r <= tcu_pkg::ROWS_RST;
      col_r      <= '0;
      row_r      <= '0;
      sw_r       <= '0;
    end else begin
      if (cfg_we && cfg_idx == tcu_pkg::CFG_COLUMNS) cfg_cols_r <= cfg_data;
      if (cfg_we && cfg_idx == tcu_pkg::CFG_ROWS)    cfg_rows_r <= cfg_data;
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (cmd.sweep) sw_r <= (sw_r == SW_LAST) ? '0 : sw_r + MAP_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    chk_r <= chk_nxt;
    if (cmd.load) begin
      op_r   <= in_op;
      trow_r <= in_trow;
      tcol_r <= in_tcol;
    end
    if (cmd.out_load) begin
      out_row_r <= row_r;
      out_col_r <= col_r;
    end
  end

  assign stat.col_zero   = (col_r == '0);
  assign stat.scan_fin   = fin;
  assign stat.sweep_last = (sw_r == SW_LAST);
  assign out_row = out_row_r;
  assign out_col = out_col_r;

endmodule

/* rtl/core/terminal_cursor_tab_unit.sv */
// Top level of the terminal cursor and tab-stop unit.
// Usage:
//   in_chan  : one request per accepted valid/ready beat: operation, count,
//              target_row, target_col. Accepted only while the unit is idle.
//   out_chan : one result per request: cursor row and column afterwards.
//   cfg_chan : register writes (index 0 columns in use, 1 rows in use);
//              always ready, other indexes ignored. Write only while idle.
// Request handling, accept to result valid:
//   stop set/clear, line moves and set cursor go through the update state;
//   a back tab from column 0 goes straight to the result. Forward/back tab:
//   one column checked per cycle, set by the single read port of the map;
//   forward walks are bounded by the screen width, backward walks by the
//   cursor column. Clear all stops: all MAX_COLUMNS (capped at 256) map
//   entries are cleared, one map entry written per cycle.
// Reset: cursor goes to 0,0 and the map is filled with a stop every eighth
//   column, one entry per cycle, over all MAX_COLUMNS (capped at 256) entries,
//   with in_chan.ready low.
// A result held in the output register does not block the next request;
//   only the completion of that next request waits for out_chan.ready.
module terminal_cursor_tab_unit #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  tcu_in_if.sink     in_chan,
  tcu_out_if.source  out_chan,
  tcu_cfg_if.sink    cfg_chan
);

  tcu_pkg::cmd_t  cmd;
  tcu_pkg::stat_t stat;

  assign cfg_chan.ready = 1'b1;

  tcu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_op     (in_chan.operation),
    .in_ready  (in_chan.ready),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  tcu_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_op    (in_chan.operation),
    .in_count (in_chan.count),
    .in_trow  (in_chan.target_row),
    .in_tcol  (in_chan.target_col),
    .cfg_we   (cfg_chan.valid),
    .cfg_idx  (cfg_chan.index),
    .cfg_data (cfg_chan.data),
    .out_row  (out_chan.row_now),
    .out_col  (out_chan.col_now)
  );

  // a request is never taken while an earlier one is still being worked
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |-> !(cmd.scan_f || cmd.scan_b || cmd.apply || cmd.sweep))
    else $error("request accepted while busy");

  // the output register is only overwritten when empty or being drained
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_chan.valid || out_chan.ready))
    else $error("result overwritten before taken");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_chan.valid)
    else $error("loaded result not presented");

  // a walk never runs together with a map write
  a_walk_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_f || cmd.scan_b) |-> !(cmd.sweep || cmd.apply || cmd.load))
    else $error("walk overlaps another map access");

endmodule

/* test/cursor_tab_monitor.sv */
// Watches the cursor/tab unit channels, predicts each result and compares it.
`timescale 1ns / 1ps

module cursor_tab_monitor
  import tcu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  tcu_in_if    in_mon,
  tcu_out_if   out_mon,
  tcu_cfg_if   cfg_mon,
  output int   err_total,
  output int   open_total
);

  localparam int MAP_COLS = 256;
  localparam int MAP_ROWS = 256;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } cursor_pos_t;

  logic [CFG_W-1:0] cols_reg;
  logic [CFG_W-1:0] rows_reg;
  logic [POS_W-1:0] cur_row;
  logic [POS_W-1:0] cur_col;
  logic             stop_map [MAP_COLS];
  cursor_pos_t      cursor_due_q [$];

  initial err_total = 0;

  function automatic int eff_size(logic [CFG_W-1:0] v, int limit);
    int top;
    top = (limit < 256) ? limit : 256;
    if (v < 1) return 1;
    if (int'(v) > top) return top;
    return int'(v);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t cursor mismatch: %s got %0d want %0d", $time, what, got, want);
    err_total = err_total + 1;
  endtask

  task automatic advance_cursor(logic [OP_W-1:0] op, logic [CNT_W-1:0] cnt,
                                logic [POS_W-1:0] trow, logic [POS_W-1:0] tcol);
    int  cols;
    int  rows;
    int  reps;
    int  c;
    int  r;
    bit  found;
    cursor_pos_t pos;
    cols = eff_size(cols_reg, MAP_COLS);
    rows = eff_size(rows_reg, MAP_ROWS);
    reps = (cnt == 0) ? 1 : int'(cnt);
    case (op)
      OP_FWD_TAB: begin
        for (int i = 0; i < reps; i++) begin
          found = 1'b0;
          for (c = int'(cur_col) + 1; c < cols; c++) begin
            if (stop_map[c]) begin
              found = 1'b1;
              break;
            end
          end
          // no stop ahead: park on the last column and stop repeating
          if (!found) begin
            cur_col = POS_W'(cols - 1);
            break;
          end
          cur_col = POS_W'(c);
        end
      end
      OP_BACK_TAB: begin
        for (int i = 0; i < reps; i++) begin
          found = 1'b0;
          for (c = int'(cur_col); c > 0; c--) begin
            if (stop_map[c-1]) begin
              found = 1'b1;
              break;
            end
          end
          if (!found) begin
            cur_col = '0;
            break;
          end
          cur_col = POS_W'(c - 1);
        end
      end
      OP_CLR_STOP: begin
        if (int'(cur_col) < cols) stop_map[cur_col] = 1'b0;
      end
      OP_CLR_ALL: begin
        foreach (stop_map[k]) stop_map[k] = 1'b0;
      end
      OP_NEXT_LINE: begin
        r = int'(cur_row) + reps;
        cur_row = POS_W'((r < rows - 1) ? r : rows - 1);
        cur_col = '0;
      end
      OP_PREV_LINE: begin
        cur_row = (int'(cur_row) > reps) ? POS_W'(int'(cur_row) - reps) : '0;
        cur_col = '0;
      end
      OP_SET_STOP: begin
        if (int'(cur_col) < cols) stop_map[cur_col] = 1'b1;
      end
      OP_SET_CUR: begin
        cur_row = (int'(trow) < rows - 1) ? trow : POS_W'(rows - 1);
        cur_col = (int'(tcol) < cols - 1) ? tcol : POS_W'(cols - 1);
      end
      default: ;
    endcase
    pos.row = cur_row;
    pos.col = cur_col;
    cursor_due_q.push_back(pos);
  endtask

  always @(posedge clk) begin
    cursor_pos_t due;
    if (!rst_n) begin
      cols_reg = COLUMNS_RST;
      rows_reg = ROWS_RST;
      cur_row  = '0;
      cur_col  = '0;
      foreach (stop_map[k]) stop_map[k] = (k % 8) == 0;
      cursor_due_q.delete();
      open_total <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == CFG_COLUMNS) cols_reg = cfg_mon.data;
        else if (cfg_mon.index == CFG_ROWS) rows_reg = cfg_mon.data;
      end
      // compare before queuing this edge's request: its result cannot be out yet
      if (out_mon.valid && out_mon.ready) begin
        if (cursor_due_q.size() == 0) begin
          report_mismatch("unexpected result row", int'(out_mon.row_now), -1);
        end else begin
          due = cursor_due_q.pop_front();
          if (out_mon.row_now !== due.row)
            report_mismatch("row_now", int'(out_mon.row_now), int'(due.row));
          if (out_mon.col_now !== due.col)
            report_mismatch("col_now", int'(out_mon.col_now), int'(due.col));
        end
      end
      if (in_mon.valid && in_mon.ready)
        advance_cursor(in_mon.operation, in_mon.count, in_mon.target_row, in_mon.target_col);
      open_total <= cursor_due_q.size();
    end
  end

endmodule

/* test/tb_terminal_cursor_tab_unit.sv */
// Stimulus and verdict for the terminal cursor and tab-stop unit.
`timescale 1ns / 1ps

module tb_terminal_cursor_tab_unit;
  import tcu_pkg::*;

  localparam int CYCLE_LIMIT   = 2_500_000;
  localparam int NUM_SEG       = 10;
  localparam int ITEMS_PER_SEG = 175;
  localparam int SEG_COLS [NUM_SEG] = '{80, 1, 256, 0, 511, 257, 132, 8, 40, 256};
  localparam int SEG_ROWS [NUM_SEG] = '{24, 1, 256, 0, 511, 300, 50, 2, 256, 1};
  // indexes the unit ignores
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE3 = 2'd3;

  logic clk;
  logic rst_n;
  int   err_total;
  int   open_total;
  int   req_gap_pct    = 0;
  int   resp_stall_pct = 0;
  int   span_cols      = 80;
  int   span_rows      = 24;
  int   cycle_count    = 0;

  tcu_in_if  in_if ();
  tcu_out_if out_if ();
  tcu_cfg_if cfg_if ();

  terminal_cursor_tab_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  cursor_tab_monitor u_monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .cfg_mon    (cfg_if),
    .err_total  (err_total),
    .open_total (open_total)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_terminal_cursor_tab_unit: errors");
      $finish;
    end
  end

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= ($urandom_range(99) >= resp_stall_pct);
    end
  end

  function automatic int clamp_span(int v);
    if (v < 1) return 1;
    if (v > 256) return 256;
    return v;
  endfunction

  // valid stays high after acceptance; the next request or an idle cycle replaces it
  task automatic send_req(logic [OP_W-1:0] op, logic [CNT_W-1:0] cnt,
                          logic [POS_W-1:0] trow, logic [POS_W-1:0] tcol);
    while ($urandom_range(99) < req_gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.operation  <= op;
    in_if.count      <= cnt;
    in_if.target_row <= trow;
    in_if.target_col <= tcol;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (open_total != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  task automatic write_regs(int cols, int rows);
    cfg_write(CFG_COLUMNS, CFG_W'(cols));
    cfg_write(CFG_ROWS, CFG_W'(rows));
    if ($urandom_range(1) == 1)
      cfg_write(($urandom_range(1) == 1) ? CFG_SPARE2 : CFG_SPARE3, CFG_W'($urandom));
    cfg_if.valid <= 1'b0;
    span_cols = clamp_span(cols);
    span_rows = clamp_span(rows);
  endtask

  task automatic send_random();
    logic [OP_W-1:0]  op;
    logic [CNT_W-1:0] cnt;
    logic [POS_W-1:0] trow;
    logic [POS_W-1:0] tcol;
    int sel;
    sel = $urandom_range(99);
    if (sel < 20)      op = OP_FWD_TAB;
    else if (sel < 35) op = OP_BACK_TAB;
    else if (sel < 43) op = OP_CLR_STOP;
    else if (sel < 46) op = OP_CLR_ALL;
    else if (sel < 56) op = OP_NEXT_LINE;
    else if (sel < 66) op = OP_PREV_LINE;
    else if (sel < 80) op = OP_SET_STOP;
    else               op = OP_SET_CUR;
    sel = $urandom_range(99);
    if (sel < 50)      cnt = CNT_W'($urandom_range(3));
    else if (sel < 80) cnt = CNT_W'($urandom_range(20));
    else if (sel < 95) cnt = CNT_W'($urandom_range(300));
    else               cnt = CNT_W'($urandom);
    // half the targets on-screen so stops land where tabs can find them
    if ($urandom_range(1) == 1) begin
      trow = POS_W'($urandom_range(span_rows - 1));
      tcol = POS_W'($urandom_range(span_cols - 1));
    end else begin
      trow = POS_W'($urandom);
      tcol = POS_W'($urandom);
    end
    send_req(op, cnt, trow, tcol);
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.operation  <= OP_FWD_TAB;
    in_if.count      <= '0;
    in_if.target_row <= '0;
    in_if.target_col <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= CFG_COLUMNS;
    cfg_if.data      <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    req_gap_pct    = 6;
    resp_stall_pct = 77;
    write_regs(80, 24);

    // power-on stops, repeat limits, line clamps, clear-all
    send_req(OP_FWD_TAB,   16'h0000, 8'd0,   8'd0);
    send_req(OP_FWD_TAB,   16'd3,    8'd0,   8'd0);
    send_req(OP_FWD_TAB,   16'hFFFF, 8'd0,   8'd0);
    send_req(OP_BACK_TAB,  16'd1,    8'd0,   8'd0);
    send_req(OP_BACK_TAB,  16'hFFFF, 8'd0,   8'd0);
    send_req(OP_BACK_TAB,  16'h0000, 8'd0,   8'd0);
    send_req(OP_SET_CUR,   16'hFFFF, 8'd255, 8'd255);
    send_req(OP_SET_STOP,  16'd0,    8'd0,   8'd0);
    send_req(OP_BACK_TAB,  16'd1,    8'd255, 8'd255);
    send_req(OP_FWD_TAB,   16'd1,    8'd0,   8'd0);
    send_req(OP_CLR_STOP,  16'hFFFF, 8'd255, 8'd255);
    send_req(OP_SET_CUR,   16'd0,    8'd5,   8'd3);
    send_req(OP_NEXT_LINE, 16'h0000, 8'd0,   8'd0);
    send_req(OP_NEXT_LINE, 16'hFFFF, 8'd0,   8'd0);
    send_req(OP_PREV_LINE, 16'd3,    8'd0,   8'd0);
    send_req(OP_PREV_LINE, 16'hFFFF, 8'd0,   8'd0);
    send_req(OP_CLR_ALL,   16'hFFFF, 8'd255, 8'd255);
    send_req(OP_FWD_TAB,   16'd2,    8'd0,   8'd0);
    send_req(OP_BACK_TAB,  16'd1,    8'd0,   8'd0);
    send_req(OP_SET_CUR,   16'd0,    8'd20,  8'd64);
    send_req(OP_SET_STOP,  16'd0,    8'd0,   8'd0);
    send_req(OP_SET_CUR,   16'd0,    8'd20,  8'd70);
    drain();

    // shrunk screen with the cursor left outside it
    write_regs(16, 4);
    send_req(OP_SET_STOP,  16'd0,    8'd0,   8'd0);
    send_req(OP_CLR_STOP,  16'd0,    8'd0,   8'd0);
    send_req(OP_BACK_TAB,  16'd1,    8'd0,   8'd0);
    send_req(OP_FWD_TAB,   16'd1,    8'd0,   8'd0);
    send_req(OP_NEXT_LINE, 16'd1,    8'd0,   8'd0);
    send_req(OP_SET_CUR,   16'd0,    8'd200, 8'd200);

    for (int s = 0; s < NUM_SEG; s++) begin
      if (s < 4) begin
        req_gap_pct    = 6;
        resp_stall_pct = 77;
      end else if (s < 7) begin
        req_gap_pct    = 77;
        resp_stall_pct = 6;
      end else begin
        req_gap_pct    = 0;
        resp_stall_pct = 0;
      end
      drain();
      if (s == NUM_SEG - 1) write_regs($urandom_range(2, 255), $urandom_range(2, 255));
      else write_regs(SEG_COLS[s], SEG_ROWS[s]);
      for (int k = 0; k < ITEMS_PER_SEG; k++) send_random();
    end

    drain();
    // clear-all is the longest request; watch that long for stray results
    repeat (300) @(posedge clk);
    if (err_total == 0) begin
      $display("tb_terminal_cursor_tab_unit: clean");
    end else begin
      $display("tb_terminal_cursor_tab_unit: errors");
    end
    $finish;
  end

endmodule

/* terminal_cursor_tab_unit.f */
rtl/core/tcu_pkg.sv
rtl/core/tcu_in_if.sv
rtl/core/tcu_out_if.sv
rtl/core/tcu_cfg_if.sv
rtl/core/tcu_ctrl.sv
rtl/core/tcu_datapath.sv
rtl/core/terminal_cursor_tab_unit.sv
test/cursor_tab_monitor.sv
test/tb_terminal_cursor_tab_unit.sv
